// ===== src/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg
// shared sizes, codes and types of the size class slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

	localparam int NUM_CLASSES       = 8;
	localparam int SLOTS_PER_CLASS   = 64;
	localparam int ALIGN_BYTES       = 8;
	localparam int MAX_REQUEST_BYTES = 4096;

	localparam int CLS_W   = 3;
	localparam int SLOT_W  = 6;
	localparam int SIZE_W  = 13;
	localparam int SUM_W   = SIZE_W + 1;
	localparam int IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_ENTRY = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// class table lookup for one request
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             spare_ok;
		logic [IDX_W-1:0] spare_idx;
		logic             free_in_use;
	} lookup_t;

	// class table update when a new class opens
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] size;
	} class_upd_t;

endpackage

`default_nettype wire

// ===== src/scba_class_table.sv =====
// ----------------------------------------------------------------------------
// scba_class_table
// per-class in-use flags and slot sizes, size match and lowest unused entry
// ----------------------------------------------------------------------------
`default_nettype none

module scba_class_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [scba_pkg::SIZE_W-1:0] size,
	input  wire logic [scba_pkg::CLS_W-1:0]  free_class,
	input  wire scba_pkg::class_upd_t        upd,
	output scba_pkg::lookup_t                lookup
);
	import scba_pkg::*;

	logic              in_use_q [NUM_CLASSES];
	logic [SIZE_W-1:0] size_q   [NUM_CLASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				in_use_q[i] <= 1'b0;
			end
		end else if (upd.en) begin
			in_use_q[upd.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			size_q[upd.idx] <= upd.size;
		end
	end

	always_comb begin
		lookup = '0;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if (in_use_q[i] && size_q[i] == size) begin
				lookup.hit     = 1'b1;
				lookup.hit_idx = IDX_W'(i);
			end
			if (!in_use_q[i]) begin
				lookup.spare_ok  = 1'b1;
				lookup.spare_idx = IDX_W'(i);
			end
		end
		if (int'(free_class) < NUM_CLASSES) begin
			lookup.free_in_use = in_use_q[IDX_W'(free_class)];
		end
	end

endmodule

`default_nettype wire

// ===== src/scba_slot_map.sv =====
// ----------------------------------------------------------------------------
// scba_slot_map
// occupancy bitmap memory, one row per class, with lowest free slot search
// ----------------------------------------------------------------------------
`default_nettype none

module scba_slot_map (
	input  wire logic                                clk,
	input  wire logic                                rd_en,
	input  wire logic [scba_pkg::IDX_W-1:0]          rd_idx,
	input  wire logic                                wr_en,
	input  wire logic [scba_pkg::IDX_W-1:0]          wr_idx,
	input  wire logic [scba_pkg::SLOTS_PER_CLASS-1:0] wr_data,
	output logic      [scba_pkg::SLOTS_PER_CLASS-1:0] rd_data,
	output logic                                     free_found,
	output logic      [scba_pkg::SLOT_W-1:0]         free_slot
);
	import scba_pkg::*;

	logic [SLOTS_PER_CLASS-1:0] mem [NUM_CLASSES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

	// lowest clear bit of the row just read
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = SLOTS_PER_CLASS - 1; i >= 0; i--) begin
			if (!rd_data[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/size_class_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator_top
// segregated size class allocator with one occupancy bitmap per class
// ----------------------------------------------------------------------------
// Each item passes through two states: the accept in idle looks up the class table and
// reads the class's bitmap row from the slot memory; in exec, once the output register
// is free or being read, the block picks the lowest free slot, writes a changed row back
// and loads the result register. The bitmap memory has a single registered read port. A
// new item is taken as soon as the block is back in idle, even while a result waits in
// the output register. Bitmap rows are written before a class can be used, so no
// clearing pass runs after reset.
`default_nettype none

module size_class_bitmap_allocator_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// req_size[12:0], free_class[15:13], free_slot[21:16], zero[23:22]
	input  wire logic [scba_pkg::IN_DATA_W-1:0]       s_tdata,
	// cmd[0]
	input  wire logic                                 s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// class_index[2:0], slot_index[8:3], granted_size[21:9], zero[23:22]
	output logic      [scba_pkg::OUT_DATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic      [1:0]                           m_tuser
);
	import scba_pkg::*;

	state_t state_q, state_nxt;

	logic [SIZE_W-1:0] req_size;
	logic [CLS_W-1:0]  free_class;
	logic [SLOT_W-1:0] free_slot;
	logic [SUM_W-1:0]  round_sum;
	logic [SUM_W-1:0]  rounded;
	logic              accept;
	logic              exec_fire;
	lookup_t           lookup;

	logic              cmd_s1;
	logic [SIZE_W-1:0] size_s1;
	logic              oversize_s1;
	lookup_t           lookup_s1;
	logic [CLS_W-1:0]  fcls_s1;
	logic [SLOT_W-1:0] fslot_s1;

	logic                       rd_en;
	logic [IDX_W-1:0]           rd_idx;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_idx;
	logic [SLOTS_PER_CLASS-1:0] wr_data;
	logic [SLOTS_PER_CLASS-1:0] rd_data;
	logic                       free_found;
	logic [SLOT_W-1:0]          found_slot;
	class_upd_t                 upd;

	status_t           res_status;
	logic [CLS_W-1:0]  res_class;
	logic [SLOT_W-1:0] res_slot;
	logic [SIZE_W-1:0] res_size;

	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]        m_tuser_q;

	assign req_size   = s_tdata[SIZE_W-1:0];
	assign free_class = s_tdata[SIZE_W+CLS_W-1:SIZE_W];
	assign free_slot  = s_tdata[SIZE_W+CLS_W+SLOT_W-1:SIZE_W+CLS_W];

	// round up to the alignment, at least one unit
	assign round_sum = SUM_W'(req_size) + SUM_W'(ALIGN_BYTES - 1);
	always_comb begin
		if (int'(req_size) < ALIGN_BYTES) begin
			rounded = SUM_W'(ALIGN_BYTES);
		end else begin
			rounded = SUM_W'((round_sum / ALIGN_BYTES) * ALIGN_BYTES);
		end
	end

	scba_class_table u_class_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.size       (rounded[SIZE_W-1:0]),
		.free_class (free_class),
		.upd        (upd),
		.lookup     (lookup)
	);

	assign rd_en  = accept;
	assign rd_idx = (s_tuser == CMD_FREE) ? IDX_W'(free_class) : lookup.hit_idx;

	scba_slot_map u_slot_map (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_idx     (rd_idx),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data),
		.rd_data    (rd_data),
		.free_found (free_found),
		.free_slot  (found_slot)
	);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!m_tvalid_q || m_tready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			S_IDLE:  s_tready  = 1'b1;
			S_EXEC:  exec_fire = !m_tvalid_q || m_tready;
			default: s_tready  = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= s_tuser;
			size_s1     <= rounded[SIZE_W-1:0];
			oversize_s1 <= int'(rounded) > MAX_REQUEST_BYTES;
			lookup_s1   <= lookup;
			fcls_s1     <= free_class;
			fslot_s1    <= free_slot;
		end
	end

	// modify and write back
	always_comb begin
		res_status = ST_OK;
		res_class  = '0;
		res_slot   = '0;
		res_size   = '0;
		wr_en      = 1'b0;
		wr_idx     = lookup_s1.hit_idx;
		wr_data    = rd_data;
		upd        = '0;
		upd.idx    = lookup_s1.spare_idx;
		upd.size   = size_s1;
		if (cmd_s1 == CMD_FREE) begin
			res_class = fcls_s1;
			res_slot  = fslot_s1;
			wr_idx    = IDX_W'(fcls_s1);
			if (!lookup_s1.free_in_use) begin
				res_status = ST_UNUSED;
			end else if (int'(fslot_s1) < SLOTS_PER_CLASS) begin
				wr_en   = exec_fire;
				wr_data = rd_data & ~(SLOTS_PER_CLASS'(1) << fslot_s1);
			end
		end else if (oversize_s1) begin
			res_status = ST_NO_ENTRY;
		end else if (lookup_s1.hit) begin
			res_class = CLS_W'(lookup_s1.hit_idx);
			if (!free_found) begin
				res_status = ST_FULL;
			end else begin
				res_slot = found_slot;
				res_size = size_s1;
				wr_en    = exec_fire;
				wr_data  = rd_data | (SLOTS_PER_CLASS'(1) << found_slot);
			end
		end else if (lookup_s1.spare_ok) begin
			res_class = CLS_W'(lookup_s1.spare_idx);
			res_size  = size_s1;
			wr_en     = exec_fire;
			wr_idx    = lookup_s1.spare_idx;
			wr_data   = SLOTS_PER_CLASS'(1);
			upd.en    = exec_fire;
		end else begin
			res_status = ST_NO_ENTRY;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			m_tdata_q <= OUT_DATA_W'({res_size, res_slot, res_class});
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the size class slot allocator
// ----------------------------------------------------------------------------
// A table of directed requests covers reset, size extremes, class opening,
// double free and running out of class entries. A random run follows in
// episodes: each one favors a hot class, so classes fill up, report full and
// recover through frees. Every result is checked against the allocator model
// in the bench or a fixed row's expected result, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb;

	import scba_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 500;

	typedef struct packed {
		cmd_t              cmd;
		logic [SIZE_W-1:0] req_size;
		logic [CLS_W-1:0]  free_class;
		logic [SLOT_W-1:0] free_slot;
	} alloc_req_t;

	typedef struct packed {
		status_t           status;
		logic [CLS_W-1:0]  class_index;
		logic [SLOT_W-1:0] slot_index;
		logic [SIZE_W-1:0] granted_size;
	} alloc_rsp_t;

	typedef struct {
		alloc_req_t req;
		bit         fixed;
		alloc_rsp_t rsp;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	// allocator state as the bench sees it
	bit                       class_used [NUM_CLASSES];
	logic [SIZE_W-1:0]        class_bytes[NUM_CLASSES];
	logic [SLOTS_PER_CLASS-1:0] slot_map [NUM_CLASSES];

	alloc_rsp_t owed_rsp[$];
	stim_row_t  cur_row;
	stim_row_t  dir_rows[$];

	int errors = 0;
	int n_alloc = 0;
	int n_free = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int burst_left = 0;
	int rx_mode = 0;
	int rx_left = 0;

	size_class_bitmap_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic alloc_rsp_t grant_or_release(alloc_req_t r);
		alloc_rsp_t              o;
		int                      rounded;
		int                      hit;
		int                      spare;
		logic [SLOTS_PER_CLASS-1:0] open_slots;
		o = '{ST_OK, '0, '0, '0};
		if (r.cmd == CMD_FREE) begin
			o.class_index = r.free_class;
			o.slot_index  = r.free_slot;
			if (int'(r.free_class) >= NUM_CLASSES || !class_used[r.free_class])
				o.status = ST_UNUSED;
			else if (int'(r.free_slot) < SLOTS_PER_CLASS)
				slot_map[r.free_class][r.free_slot] = 1'b0;
			return o;
		end
		if (int'(r.req_size) < ALIGN_BYTES)
			rounded = ALIGN_BYTES;
		else
			rounded = ((int'(r.req_size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		if (rounded > MAX_REQUEST_BYTES) begin
			o.status = ST_NO_ENTRY;
			return o;
		end
		hit = -1;
		spare = -1;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (class_used[i]) begin
				if (hit < 0 && int'(class_bytes[i]) == rounded)
					hit = i;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (hit < 0) begin
			if (spare < 0) begin
				o.status = ST_NO_ENTRY;
				return o;
			end
			class_used[spare]  = 1'b1;
			class_bytes[spare] = rounded[SIZE_W-1:0];
			slot_map[spare]    = SLOTS_PER_CLASS'(1);
			o.class_index  = spare[CLS_W-1:0];
			o.granted_size = rounded[SIZE_W-1:0];
			return o;
		end
		o.class_index = hit[CLS_W-1:0];
		open_slots = ~slot_map[hit];
		if (open_slots == '0) begin
			o.status = ST_FULL;
			return o;
		end
		for (int s = SLOTS_PER_CLASS - 1; s >= 0; s--)
			if (open_slots[s])
				o.slot_index = s[SLOT_W-1:0];
		slot_map[hit][o.slot_index] = 1'b1;
		o.granted_size = rounded[SIZE_W-1:0];
		return o;
	endfunction

	function automatic stim_row_t mk(cmd_t c, int req, int fc, int fs, bit fixed = 1'b0,
			status_t st = ST_OK, int cls = 0, int slot = 0, int size = 0);
		stim_row_t r;
		r.req   = '{c, req[SIZE_W-1:0], fc[CLS_W-1:0], fs[SLOT_W-1:0]};
		r.fixed = fixed;
		r.rsp   = '{st, cls[CLS_W-1:0], slot[SLOT_W-1:0], size[SIZE_W-1:0]};
		return r;
	endfunction

	function automatic stim_row_t pick_random_row(int hot);
		int        roll;
		int        k;
		int        sz;
		stim_row_t r;
		roll = $urandom_range(0, 99);
		r = mk(CMD_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 7), $urandom_range(0, 63));
		if (roll < 75) begin
			k = (roll < 65) ? hot : $urandom_range(0, NUM_CLASSES - 1);
			if (class_used[k]) begin
				sz = int'(class_bytes[k]);
				r.req.req_size = SIZE_W'((sz == ALIGN_BYTES) ? $urandom_range(0, ALIGN_BYTES)
					: $urandom_range(sz - ALIGN_BYTES + 1, sz));
			end
		end else if (roll >= 82) begin
			r.req.cmd = CMD_FREE;
			if (roll < 91)
				r.req.free_class = hot[CLS_W-1:0];
		end
		return r;
	endfunction

	task automatic drive_item(input stim_row_t row);
		s_tvalid <= 1'b1;
		s_tuser  <= row.req.cmd;
		s_tdata  <= {2'b00, row.req.free_slot, row.req.free_class, row.req.req_size};
		cur_row  <= row;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (owed_rsp.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(10, 60);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 0);
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= (rx_left < 3);
		endcase
	end

	always @(posedge clk) begin
		alloc_req_t seen;
		alloc_rsp_t want;
		alloc_rsp_t got;
		if (arst_n && s_tvalid && s_tready) begin
			seen = '{cmd_t'(s_tuser), s_tdata[12:0], s_tdata[15:13], s_tdata[21:16]};
			want = grant_or_release(seen);
			if (cur_row.fixed)
				want = cur_row.rsp;
			owed_rsp.push_back(want);
			if (seen.cmd == CMD_FREE)
				n_free++;
			else
				n_alloc++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status_t'(m_tuser), m_tdata[2:0], m_tdata[8:3], m_tdata[21:9]};
			status_seen[got.status]++;
			if (owed_rsp.size() == 0) begin
				$error("result with nothing pending: status %0d class %0d slot %0d size %0d",
					got.status, got.class_index, got.slot_index, got.granted_size);
				errors++;
			end else begin
				want = owed_rsp.pop_front();
				if (got.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.class_index != want.class_index) begin
					$error("class_index: expected %0d, got %0d",
						want.class_index, got.class_index);
					errors++;
				end
				if (got.slot_index != want.slot_index) begin
					$error("slot_index: expected %0d, got %0d",
						want.slot_index, got.slot_index);
					errors++;
				end
				if (got.granted_size != want.granted_size) begin
					$error("granted_size: expected %0d, got %0d",
						want.granted_size, got.granted_size);
					errors++;
				end
			end
		end
	end

	initial begin
		int sent;
		int hot;
		int episode;
		int ep_left;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			class_used[i]  = 1'b0;
			class_bytes[i] = '0;
			slot_map[i]    = '0;
		end
		dir_rows = '{
			mk(CMD_FREE,     0, 0,  0, 1, ST_UNUSED,   0,  0,    0),
			mk(CMD_FREE,  8191, 7, 63, 1, ST_UNUSED,   7, 63,    0),
			mk(CMD_ALLOC,    0, 7, 63, 1, ST_OK,       0,  0,    8),
			mk(CMD_ALLOC,    1, 0,  0),
			mk(CMD_ALLOC,    8, 5, 21),
			mk(CMD_ALLOC,    9, 2, 42),
			mk(CMD_ALLOC, 4096, 0,  0, 1, ST_OK,       2,  0, 4096),
			mk(CMD_ALLOC, 4095, 0,  0),
			mk(CMD_ALLOC, 4097, 0,  0, 1, ST_NO_ENTRY, 0,  0,    0),
			mk(CMD_ALLOC, 8191, 7, 63, 1, ST_NO_ENTRY, 0,  0,    0),
			mk(CMD_FREE,  4096, 0,  1),
			mk(CMD_FREE,     0, 0,  1),
			mk(CMD_ALLOC,    3, 0,  0),
			mk(CMD_FREE,     0, 3,  5, 1, ST_UNUSED,   3,  5,    0),
			mk(CMD_ALLOC,   17, 0,  0),
			mk(CMD_ALLOC,   32, 0,  0),
			mk(CMD_ALLOC,   33, 0,  0),
			mk(CMD_ALLOC,   48, 0,  0),
			mk(CMD_ALLOC,   56, 0,  0),
			mk(CMD_ALLOC,   64, 0,  0, 1, ST_NO_ENTRY, 0,  0,    0),
			mk(CMD_FREE,     0, 7,  0),
			mk(CMD_ALLOC,   50, 0,  0),
			mk(CMD_FREE,     0, 2, 63),
			mk(CMD_FREE,     0, 1,  0),
			mk(CMD_ALLOC,   16, 0,  0)
		};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			drive_item(dir_rows[i]);
			pace_sender();
		end
		drain_results();

		sent = 0;
		episode = 0;
		ep_left = 0;
		hot = 0;
		while (sent < RANDOM_ITEMS) begin
			if (ep_left == 0) begin
				episode++;
				hot = $urandom_range(0, NUM_CLASSES - 1);
				ep_left = $urandom_range(80, 130);
				// let the block run dry once mid-run
				if (episode == 3)
					drain_results();
			end
			drive_item(pick_random_row(hot));
			pace_sender();
			ep_left--;
			sent++;
		end
		drain_results();
		repeat (8) @(posedge clk);

		$display("covered %0d allocate and %0d free items over %0d hot-class episodes",
			n_alloc, n_free, episode);
		$display("results: %0d ok, %0d class full, %0d no entry, %0d unused class",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NO_ENTRY],
			status_seen[ST_UNUSED]);
		if (errors == 0 && owed_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
